// ===== src/pidc_pkg.sv =====
// Shared types, register indexes and widths for the clamped-integral PID controller.
package pidc_pkg;

  localparam int ERR_W    = 17;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int TD_W     = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 31;
  localparam int INTG_W   = 32;
  localparam int SUM_W    = INTG_W + 2;
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int DRIVE_W  = 32;
  localparam int FRAC_W   = 8;
  localparam int DIV_STEPS = ERR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTG_GAIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INTG_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SET_POINT  = 3'd4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  typedef enum logic [1:0] {
    MUL_ERR_TD,
    MUL_PROP,
    MUL_INTG,
    MUL_DERIV
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     int_upd;
    logic     acc_clr;
    logic     acc_add;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

// ===== src/pidc_div.sv =====
// Restoring serial divider: one quotient bit per cycle for the derivative magnitude.
module pidc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pidc_pkg::ERR_W-1:0] dividend,
  input  logic [pidc_pkg::TD_W-1:0]  divisor,
  output logic                      busy,
  output logic [pidc_pkg::ERR_W-1:0] quotient
);

  logic [pidc_pkg::ERR_W-1:0]     q_r, q_nxt;
  logic [pidc_pkg::ERR_W-1:0]     rem_r, rem_nxt;
  logic [pidc_pkg::ERR_W-1:0]     rem_sh;
  logic [pidc_pkg::TD_W-1:0]      dsr_r;
  logic [pidc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           ge;

  always_comb begin
    rem_sh  = {rem_r[pidc_pkg::ERR_W-2:0], q_r[pidc_pkg::ERR_W-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
    q_nxt   = {q_r[pidc_pkg::ERR_W-2:0], ge};
    cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;

endmodule

// ===== src/pidc_dp.sv =====
// Datapath: configuration registers, loop state, shared multiplier, accumulator and output word.
module pidc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pidc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [15:0]                     position,
  input  logic [pidc_pkg::TD_W-1:0]       time_delta,
  input  pidc_pkg::cmd_t                  cmd,
  output pidc_pkg::sts_t                  sts,
  output logic [pidc_pkg::DRIVE_W-1:0]    drive,
  output logic [pidc_pkg::ERR_W-1:0]      proportional_term,
  output logic [pidc_pkg::INTG_W-1:0]     integral_term,
  output logic [pidc_pkg::ERR_W-1:0]      derivative_term,
  output logic                            zero_time
);

  logic signed [pidc_pkg::GAIN_W-1:0]  kp_r, ki_r, kd_r, sp_r;
  logic        [pidc_pkg::LIMIT_W-1:0] lim_r;

  logic signed [pidc_pkg::ERR_W-1:0]   err_r, prev_r;
  logic        [pidc_pkg::TD_W-1:0]    td_r;
  logic                                zero_r;
  logic                                neg_r;
  logic signed [pidc_pkg::INTG_W-1:0]  int_r, int_nxt;
  logic signed [pidc_pkg::PROD_W-1:0]  prod_r;
  logic signed [pidc_pkg::ACC_W-1:0]   acc_r;

  logic signed [pidc_pkg::ERR_W-1:0]   err_nxt;
  logic signed [pidc_pkg::DIFF_W-1:0]  diff;
  logic        [pidc_pkg::DIFF_W-1:0]  diff_neg;
  logic        [pidc_pkg::ERR_W-1:0]   diff_mag;
  logic signed [pidc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pidc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pidc_pkg::SUM_W-1:0]   sum, lim_pos, lim_neg;
  logic        [pidc_pkg::ERR_W-1:0]   quot;
  logic        [pidc_pkg::ERR_W-1:0]   quot_sat;
  logic signed [pidc_pkg::ERR_W-1:0]   deriv;
  logic signed [pidc_pkg::ACC_W-pidc_pkg::FRAC_W-1:0] shifted;
  logic        [pidc_pkg::DRIVE_W-1:0] drive_sat;
  logic                                div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= '0;
      ki_r  <= '0;
      kd_r  <= '0;
      lim_r <= pidc_pkg::LIMIT_RESET;
      sp_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pidc_pkg::REG_PROP_GAIN:  kp_r  <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_INTG_GAIN:  ki_r  <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_DERIV_GAIN: kd_r  <= cfg_data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_INTG_LIMIT: lim_r <= cfg_data[pidc_pkg::LIMIT_W-1:0];
        pidc_pkg::REG_SET_POINT:  sp_r  <= cfg_data[pidc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    err_nxt  = $signed({sp_r[15], sp_r}) - $signed({position[15], position});
    diff     = $signed({err_r[pidc_pkg::ERR_W-1], err_r}) -
               $signed({prev_r[pidc_pkg::ERR_W-1], prev_r});
    diff_neg = -diff;
    diff_mag = diff[pidc_pkg::DIFF_W-1] ? diff_neg[pidc_pkg::ERR_W-1:0]
                                        : diff[pidc_pkg::ERR_W-1:0];
  end

  always_comb begin
    unique case (cmd.mul_sel)
      pidc_pkg::MUL_ERR_TD: begin
        mul_a = pidc_pkg::MUL_A_W'(err_r);
        mul_b = $signed({1'b0, td_r});
      end
      pidc_pkg::MUL_PROP: begin
        mul_a = pidc_pkg::MUL_A_W'(err_r);
        mul_b = pidc_pkg::MUL_B_W'(kp_r);
      end
      pidc_pkg::MUL_INTG: begin
        mul_a = int_r;
        mul_b = pidc_pkg::MUL_B_W'(ki_r);
      end
      pidc_pkg::MUL_DERIV: begin
        mul_a = pidc_pkg::MUL_A_W'(deriv);
        mul_b = pidc_pkg::MUL_B_W'(kd_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sum     = pidc_pkg::SUM_W'(int_r) + prod_r[pidc_pkg::SUM_W-1:0];
    lim_pos = $signed({3'b000, lim_r});
    lim_neg = -lim_pos;
    if (sum > lim_pos || sum < lim_neg) begin
      int_nxt = sum[pidc_pkg::SUM_W-1] ? lim_neg[pidc_pkg::INTG_W-1:0]
                                       : lim_pos[pidc_pkg::INTG_W-1:0];
    end else begin
      int_nxt = sum[pidc_pkg::INTG_W-1:0];
    end
  end

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.prep),
    .dividend (diff_mag),
    .divisor  (td_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_comb begin
    quot_sat = quot[pidc_pkg::ERR_W-1] ? {1'b0, {(pidc_pkg::ERR_W-1){1'b1}}} : quot;
    if (zero_r) begin
      deriv = '0;
    end else if (neg_r) begin
      deriv = -$signed(quot_sat);
    end else begin
      deriv = $signed(quot_sat);
    end
  end

  always_comb begin
    shifted = acc_r[pidc_pkg::ACC_W-1:pidc_pkg::FRAC_W];
    if (shifted[pidc_pkg::ACC_W-pidc_pkg::FRAC_W-1:pidc_pkg::DRIVE_W-1] !=
        {(pidc_pkg::ACC_W-pidc_pkg::FRAC_W-pidc_pkg::DRIVE_W+1)
         {shifted[pidc_pkg::ACC_W-pidc_pkg::FRAC_W-1]}}) begin
      drive_sat = shifted[pidc_pkg::ACC_W-pidc_pkg::FRAC_W-1]
                  ? {1'b1, {(pidc_pkg::DRIVE_W-1){1'b0}}}
                  : {1'b0, {(pidc_pkg::DRIVE_W-1){1'b1}}};
    end else begin
      drive_sat = shifted[pidc_pkg::DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r  <= '0;
      prev_r <= '0;
    end else begin
      if (cmd.prep) begin
        prev_r <= err_r;
      end
      if (cmd.int_upd) begin
        int_r <= int_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r  <= err_nxt;
      td_r   <= time_delta;
      zero_r <= (time_delta == '0);
    end
    if (cmd.prep) begin
      neg_r <= diff[pidc_pkg::DIFF_W-1];
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.acc_clr) begin
      acc_r <= pidc_pkg::ACC_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + pidc_pkg::ACC_W'(prod_r);
    end
    if (cmd.out_load) begin
      drive             <= drive_sat;
      proportional_term <= err_r;
      integral_term     <= int_r;
      derivative_term   <= deriv;
      zero_time         <= zero_r;
    end
  end

  assign sts.div_busy = div_busy;

endmodule

// ===== src/pidc_ctrl.sv =====
// Controller: sequences one sample through the datapath and owns the handshakes.
module pidc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  pidc_pkg::sts_t sts,
  output pidc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_INT,
    S_MULI,
    S_ACCI,
    S_DIVW,
    S_ACCD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = pidc_pkg::MUL_ERR_TD;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidc_pkg::MUL_ERR_TD;
        state_nxt   = S_INT;
      end
      S_INT: begin
        cmd.int_upd = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidc_pkg::MUL_PROP;
        state_nxt   = S_MULI;
      end
      S_MULI: begin
        cmd.acc_clr = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidc_pkg::MUL_INTG;
        state_nxt   = S_ACCI;
      end
      S_ACCI: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_DIVW;
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = pidc_pkg::MUL_DERIV;
          state_nxt   = S_ACCD;
        end
      end
      S_ACCD: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result word overwritten while still pending");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_PREP && !in_tready))
    else $error("accepted word did not start the sequence");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVW && !sts.div_busy) |=> state_r == S_ACCD)
    else $error("divider finished but derivative product not taken");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise valid");

endmodule

// ===== src/pid_controller_clamped_integral.sv =====
// Top level of the PID controller with clamped integral and serial derivative divider.
// One input word (position, elapsed ticks) produces one result word; the sequence uses the
// shared 32x17 multiplier and the 17-step restoring divider for the derivative, and a new word
// is taken only once the previous result has been loaded into the output register.
// A finished result waits in the output register while the next word is accepted and
// processed. Configuration writes are always accepted, one per cycle.
module pid_controller_clamped_integral (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // position[15:0], time_delta[31:16]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // drive[31:0], proportional_term[48:32], integral_term[80:49],
  // derivative_term[97:81], zero padding[103:98]
  output logic [103:0]                    out_tdata,
  output logic                            out_tuser,  // zero_time[0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pidc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data
);

  pidc_pkg::cmd_t cmd;
  pidc_pkg::sts_t sts;

  logic [pidc_pkg::DRIVE_W-1:0] drive;
  logic [pidc_pkg::ERR_W-1:0]   proportional_term;
  logic [pidc_pkg::INTG_W-1:0]  integral_term;
  logic [pidc_pkg::ERR_W-1:0]   derivative_term;
  logic                         zero_time;

  assign cfg_ready = 1'b1;

  pidc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pidc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .position          (in_tdata[15:0]),
    .time_delta        (in_tdata[31:16]),
    .cmd               (cmd),
    .sts               (sts),
    .drive             (drive),
    .proportional_term (proportional_term),
    .integral_term     (integral_term),
    .derivative_term   (derivative_term),
    .zero_time         (zero_time)
  );

  assign out_tdata = {6'b000000, derivative_term, integral_term, proportional_term, drive};
  assign out_tuser = zero_time;

endmodule
